### rtl/core/pfcp_pkg.sv
`timescale 1ns / 1ps

package pfcp_pkg;

	// Field and register widths.
	localparam int TS_W       = 32;
	localparam int CREDIT_W   = 32;
	localparam int BPT_W      = 16;
	localparam int INTV_W     = 20;
	localparam int FB_W       = 16;
	localparam int UNSENT_W   = 2;
	localparam int FRAMES_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// Shared adder width and the product width of the serial multiply.
	localparam int ALU_W      = 64;
	localparam int PROD_W     = BPT_W + TS_W;
	localparam int MUL_STEPS  = BPT_W;
	localparam int DIV_STEPS  = CREDIT_W;
	localparam int CNT_W      = 5;

	// Defaults of the top-level parameters.
	localparam int MAX_FRAMES_DEF = 3;
	localparam int FRAC_BITS_DEF  = 8;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_TICK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_US    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BYTES    = 2'd2;

	// Register reset values.
	localparam logic [BPT_W-1:0]  BPT_RST  = 16'd3840;
	localparam logic [INTV_W-1:0] INTV_RST = 20'd20000;
	localparam logic [FB_W-1:0]   FB_RST   = 16'd4096;

	// Item kinds.
	localparam logic KIND_TICK      = 1'b0;
	localparam logic KIND_UNDERFLOW = 1'b1;

	typedef struct packed {
		logic [BPT_W-1:0]  bpt;
		logic [INTV_W-1:0] intv;
		logic [FB_W-1:0]   fb;
	} cfg_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W-1:0] y;
		logic             co;
	} alu_rsp_t;

endpackage

### rtl/core/pcm_frame_credit_pacer.sv
`timescale 1ns / 1ps

// Channel  Handshake               Payload
// in       in_valid / in_ready     kind, timestamp_us, unsent_frames
// out      out_valid / out_ready   frames_due
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A tick passes from acceptance to result through the elapsed time, the shift-add multiply,
// a range check, the restoring divide, a credit add, the frame count and the load of the
// output register, all on one shared 64-bit adder. A tick whose increment overflows the
// credit skips the divide and the add. An underflow item adds the refund for the high bit
// of its count, then for the low bit, and gives no result. in_ready is high only when idle.
// Reset clears credit, the last timestamp and the registers to their defaults; a stalled
// result holds in the output register while the block finishes the next item behind it.

module pcm_frame_credit_pacer import pfcp_pkg::*; #(
	parameter int MAX_FRAMES_PER_TICK = MAX_FRAMES_DEF,
	parameter int CREDIT_FRAC_BITS    = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  kind,
	input  logic [TS_W-1:0]       timestamp_us,
	input  logic [UNSENT_W-1:0]   unsent_frames,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [FRAMES_W-1:0]   frames_due,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int FC_W   = FB_W + CREDIT_FRAC_BITS;
	localparam int FCNT_W = $clog2(MAX_FRAMES_PER_TICK + 1);
	localparam logic [FCNT_W+1:0] MAX_EXT = (FCNT_W + 2)'(MAX_FRAMES_PER_TICK);

	typedef enum logic [3:0] {
		S_IDLE, S_UF_HI, S_UF_LO, S_ELAP, S_MUL, S_DCHK, S_DIV, S_ADD, S_FRAME, S_OUT
	} state_t;

	cfg_t     cfg;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	state_t                state_q;
	logic [CREDIT_W-1:0]   credit_q;
	logic [TS_W-1:0]       last_time_q;
	logic                  seen_q;
	logic [TS_W-1:0]       ts_q;
	logic [UNSENT_W-1:0]   unsent_q;
	logic [ALU_W-1:0]      acc_q;
	logic [PROD_W-1:0]     mcand_q;
	logic [BPT_W-1:0]      mplier_q;
	logic [INTV_W-1:0]     rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [FCNT_W-1:0]     fcnt_q;
	logic [FRAMES_W-1:0]   res_q;
	logic                  out_valid_q;
	logic [FRAMES_W-1:0]   frames_q;

	logic [INTV_W-1:0]     div_eff;
	logic [FB_W-1:0]       fb_eff;
	logic [FC_W-1:0]       fc;
	logic [ALU_W-1:0]      prod_next;
	logic [TS_W-1:0]       elapsed;
	logic [FCNT_W+1:0]     fcnt_ext;

	pfcp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pfcp_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// A zero divisor or frame size is taken as one.
	assign div_eff  = (cfg.intv == '0) ? INTV_W'(1) : cfg.intv;
	assign fb_eff   = (cfg.fb == '0) ? FB_W'(1) : cfg.fb;
	assign fc       = FC_W'(fb_eff) << CREDIT_FRAC_BITS;
	assign fcnt_ext = {2'b00, fcnt_q};

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign frames_due = frames_q;

	// Operand selection for the shared adder.
	always_comb begin
		alu_req.a   = '0;
		alu_req.b   = '0;
		alu_req.sub = 1'b0;
		unique case (state_q)
			S_UF_HI: begin
				alu_req.a = ALU_W'(credit_q);
				alu_req.b = unsent_q[1] ? (ALU_W'(fc) << 1) : '0;
			end
			S_UF_LO: begin
				alu_req.a = acc_q;
				alu_req.b = unsent_q[0] ? ALU_W'(fc) : '0;
			end
			S_ELAP: begin
				alu_req.a   = ALU_W'(ts_q);
				alu_req.b   = ALU_W'(last_time_q);
				alu_req.sub = 1'b1;
			end
			S_MUL: begin
				alu_req.a = acc_q;
				alu_req.b = ALU_W'(mcand_q);
			end
			S_DCHK: begin
				alu_req.a   = ALU_W'(acc_q[ALU_W-1:CREDIT_W]);
				alu_req.b   = ALU_W'(div_eff);
				alu_req.sub = 1'b1;
			end
			S_DIV: begin
				alu_req.a   = ALU_W'({rem_q, acc_q[CREDIT_W-1]});
				alu_req.b   = ALU_W'(div_eff);
				alu_req.sub = 1'b1;
			end
			S_ADD: begin
				alu_req.a = ALU_W'(credit_q);
				alu_req.b = ALU_W'(acc_q[CREDIT_W-1:0]);
			end
			S_FRAME: begin
				alu_req.a   = ALU_W'(credit_q);
				alu_req.b   = ALU_W'(fc);
				alu_req.sub = 1'b1;
			end
			default: ;
		endcase
	end

	// Partial product update and the elapsed time of a tick.
	always_comb begin
		prod_next = mplier_q[0] ? alu_rsp.y : acc_q;
		elapsed   = seen_q ? alu_rsp.y[TS_W-1:0] : TS_W'(cfg.intv);
	end

	// Sequencer with the pacing state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			credit_q    <= '0;
			last_time_q <= '0;
			seen_q      <= 1'b0;
			ts_q        <= '0;
			unsent_q    <= '0;
			acc_q       <= '0;
			mcand_q     <= '0;
			mplier_q    <= '0;
			rem_q       <= '0;
			cnt_q       <= '0;
			fcnt_q      <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			frames_q    <= '0;
		end else begin
			// The output register loads a new result or empties when its item is taken.
			if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (kind == KIND_UNDERFLOW) begin
							unsent_q <= unsent_frames;
							state_q  <= S_UF_HI;
						end else begin
							ts_q    <= timestamp_us;
							state_q <= S_ELAP;
						end
					end
				end
				S_UF_HI: begin
					acc_q   <= alu_rsp.y;
					state_q <= S_UF_LO;
				end
				S_UF_LO: begin
					// The refund saturates the credit.
					credit_q <= (|alu_rsp.y[ALU_W-1:CREDIT_W]) ? '1
						: alu_rsp.y[CREDIT_W-1:0];
					state_q  <= S_IDLE;
				end
				S_ELAP: begin
					mcand_q     <= PROD_W'(elapsed);
					mplier_q    <= cfg.bpt;
					acc_q       <= '0;
					cnt_q       <= '0;
					last_time_q <= ts_q;
					seen_q      <= 1'b1;
					state_q     <= S_MUL;
				end
				S_MUL: begin
					// One multiplier bit a cycle; the last step applies the fraction shift.
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
						acc_q   <= prod_next << CREDIT_FRAC_BITS;
						state_q <= S_DCHK;
					end else begin
						acc_q <= prod_next;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DCHK: begin
					// A quotient of 2^32 or more saturates the credit outright.
					if (alu_rsp.co) begin
						credit_q <= '1;
						fcnt_q   <= '0;
						state_q  <= S_FRAME;
					end else begin
						rem_q   <= acc_q[CREDIT_W+INTV_W-1:CREDIT_W];
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// Restoring divide; quotient bits shift in behind the dividend.
					rem_q <= alu_rsp.co ? alu_rsp.y[INTV_W-1:0]
						: {rem_q[INTV_W-2:0], acc_q[CREDIT_W-1]};
					acc_q[CREDIT_W-1:0] <= {acc_q[CREDIT_W-2:0], alu_rsp.co};
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= S_ADD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ADD: begin
					credit_q <= alu_rsp.y[CREDIT_W] ? '1 : alu_rsp.y[CREDIT_W-1:0];
					fcnt_q   <= '0;
					state_q  <= S_FRAME;
				end
				S_FRAME: begin
					// Take one frame of credit a cycle; one more than the cap clears it.
					if (alu_rsp.co) begin
						if (fcnt_ext == MAX_EXT) begin
							res_q    <= MAX_EXT[FRAMES_W-1:0];
							credit_q <= '0;
							state_q  <= S_OUT;
						end else begin
							credit_q <= alu_rsp.y[CREDIT_W-1:0];
							fcnt_q   <= fcnt_q + 1'b1;
						end
					end else begin
						res_q   <= fcnt_ext[FRAMES_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						frames_q <= res_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/pfcp_alu.sv
`timescale 1ns / 1ps

module pfcp_alu import pfcp_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	// One adder serves add and subtract; on subtract the carry out means no borrow.
	logic [ALU_W:0] sum;

	assign sum = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
		+ {{ALU_W{1'b0}}, req.sub};
	assign rsp.y  = sum[ALU_W-1:0];
	assign rsp.co = sum[ALU_W];

endmodule

### rtl/core/pfcp_cfg.sv
`timescale 1ns / 1ps

module pfcp_cfg import pfcp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// Writes are taken in every cycle.
	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	// Register file; an index past the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpt  <= BPT_RST;
			cfg_q.intv <= INTV_RST;
			cfg_q.fb   <= FB_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BYTES_PER_TICK: cfg_q.bpt  <= cfg_data[BPT_W-1:0];
				REG_INTERVAL_US:    cfg_q.intv <= cfg_data[INTV_W-1:0];
				REG_FRAME_BYTES:    cfg_q.fb   <= cfg_data[FB_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/core/pfcp_checker.sv
`timescale 1ns / 1ps

module pfcp_checker import pfcp_pkg::*; #(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  kind,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [FRAMES_W-1:0]   frames_due
);

	// The block works on one item at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after an accepted item");

	// An underflow item gives no result and leaves the block idle when it finishes.
	a_underflow_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind == KIND_UNDERFLOW)
		|=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result raised after an underflow item");

	a_underflow_done: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind == KIND_UNDERFLOW) |-> ##3 in_ready)
		else $error("underflow item not finished in three cycles");

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(frames_due)))
		else $error("result changed or dropped while stalled");

	// The frame count never passes the cap.
	a_frames_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({30'b0, frames_due} <= MAX_FRAMES))
		else $error("frames_due above the cap");

endmodule

bind pcm_frame_credit_pacer pfcp_checker #(
	.MAX_FRAMES (MAX_FRAMES_PER_TICK)
) u_pfcp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.kind       (kind),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.frames_due (frames_due)
);

### tb/pcm_frame_credit_pacer_test.sv
`timescale 1ns / 1ps

module pcm_frame_credit_pacer_test;
	import pfcp_pkg::*;

	localparam int MAX_FRAMES     = MAX_FRAMES_DEF;
	localparam int FRAC           = FRAC_BITS_DEF;
	localparam int HOLD_CYCLES    = 1500;
	localparam int SETTLE_CYCLES  = 64;
	localparam int WATCHDOG_LIMIT = 8000;

	typedef struct {
		logic                kind;
		logic [TS_W-1:0]     ts;
		logic [UNSENT_W-1:0] unsent;
	} pacer_item_t;

	// Clock, reset and the block's inputs, all known from time zero.
	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  in_valid      = 1'b0;
	logic                  kind          = 1'b0;
	logic [TS_W-1:0]       timestamp_us  = '0;
	logic [UNSENT_W-1:0]   unsent_frames = '0;
	logic                  out_ready     = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  in_ready;
	logic                  out_valid;
	logic [FRAMES_W-1:0]   frames_due;
	logic                  cfg_ready;

	// Stimulus and expectation stores.
	pacer_item_t         pending_items[$];
	logic [FRAMES_W-1:0] expected_frames[$];
	pacer_item_t         drv_item;
	int unsigned         send_idle_pct  = 0;
	int unsigned         recv_stall_pct = 0;
	logic                long_hold      = 1'b0;
	int unsigned         hold_cnt       = 0;
	int unsigned         stim_intv      = 32'(INTV_RST);
	logic [TS_W-1:0]     gen_ts         = '0;
	int unsigned         error_count    = 0;
	int unsigned         idle_cycles    = 0;
	bit                  item_moved;

	// Predicted pacer state and registers.
	logic [CREDIT_W-1:0] credit_q    = '0;
	logic [TS_W-1:0]     last_ts_q   = '0;
	logic                seen_tick_q = 1'b0;
	logic [BPT_W-1:0]    bpt_q       = BPT_RST;
	logic [INTV_W-1:0]   intv_q      = INTV_RST;
	logic [FB_W-1:0]     fb_q        = FB_RST;

	pcm_frame_credit_pacer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.timestamp_us (timestamp_us),
		.unsent_frames(unsent_frames),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frames_due   (frames_due),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Credit addition that sticks at the top of the 32-bit range.
	function automatic logic [CREDIT_W-1:0] credit_add(input logic [CREDIT_W-1:0] a,
			input logic [63:0] b);
		logic [64:0] sum;
		sum = {33'b0, a} + {1'b0, b};
		if (sum > 65'hFFFF_FFFF) return '1;
		return sum[CREDIT_W-1:0];
	endfunction

	// Credit worth one frame; a zero frame size counts as one byte.
	function automatic logic [63:0] frame_credit();
		logic [63:0] fb;
		fb = (fb_q == '0) ? 64'd1 : 64'(fb_q);
		return fb << FRAC;
	endfunction

	// A tick adds credit for the elapsed time and takes whole frames out of it.
	function automatic logic [FRAMES_W-1:0] pace_tick(input logic [TS_W-1:0] ts);
		logic [63:0]     div;
		logic [TS_W-1:0] elapsed;
		logic [63:0]     num;
		logic [63:0]     fc;
		logic [63:0]     n;
		fc = frame_credit();
		div = (intv_q == '0) ? 64'd1 : 64'(intv_q);
		elapsed = seen_tick_q ? ts - last_ts_q : TS_W'(intv_q);
		num = (64'(bpt_q) * 64'(elapsed)) << FRAC;
		credit_q = credit_add(credit_q, num / div);
		last_ts_q = ts;
		seen_tick_q = 1'b1;
		n = 64'(credit_q) / fc;
		if (n > MAX_FRAMES) begin
			n = 64'(MAX_FRAMES);
			credit_q = '0;
		end else begin
			credit_q = credit_q - CREDIT_W'(n * fc);
		end
		return n[FRAMES_W-1:0];
	endfunction

	// An underflow hands back the credit of the frames that were not sent.
	function automatic void credit_refund(input logic [UNSENT_W-1:0] unsent);
		credit_q = credit_add(credit_q, 64'(unsent) * frame_credit());
	endfunction

	function automatic void report_error(input string msg);
		error_count++;
		if (error_count <= 10) $display("%0t: %s", $realtime, msg);
	endfunction

	// Driver: offers the next pending item, idling at random between items.
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_item = pending_items.pop_front();
				in_valid <= 1'b1;
				kind <= drv_item.kind;
				timestamp_us <= drv_item.ts;
				unsent_frames <= drv_item.unsent;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, or one long hold-off when requested.
	always @(posedge clk) begin
		if (long_hold && hold_cnt < HOLD_CYCLES) begin
			out_ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else begin
			if (!long_hold) hold_cnt <= 0;
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Monitor: updates the prediction on every accepted item and checks results.
	always @(posedge clk) begin
		if (arst_n) begin
			item_moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_BYTES_PER_TICK: bpt_q = cfg_data[BPT_W-1:0];
					REG_INTERVAL_US:    intv_q = cfg_data[INTV_W-1:0];
					REG_FRAME_BYTES:    fb_q = cfg_data[FB_W-1:0];
					default: ;
				endcase
				item_moved = 1'b1;
			end
			if (in_valid && in_ready) begin
				if (kind == KIND_UNDERFLOW) begin
					credit_refund(unsent_frames);
				end else begin
					expected_frames.push_back(pace_tick(timestamp_us));
				end
				item_moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				if (expected_frames.size() == 0) begin
					report_error($sformatf("unexpected item: frames_due %0d", frames_due));
				end else if (frames_due !== expected_frames[0]) begin
					report_error($sformatf("frames_due: expected %0d, got %0d",
						expected_frames[0], frames_due));
					void'(expected_frames.pop_front());
				end else begin
					void'(expected_frames.pop_front());
				end
				item_moved = 1'b1;
			end
			// Watchdog on cycles in which nothing moves on any channel.
			if (item_moved) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: nothing accepted for %0d cycles", idle_cycles);
				$display("FAIL pcm_frame_credit_pacer");
				$finish;
			end
		end
	end

	task automatic push_item(input logic k, input logic [TS_W-1:0] ts,
			input logic [UNSENT_W-1:0] unsent);
		pacer_item_t it;
		it.kind = k;
		it.ts = ts;
		it.unsent = unsent;
		pending_items.push_back(it);
	endtask

	// Random items: ticks mostly near the nominal interval, some jitter, jumps and
	// backward steps; underflows carry random counts and random unused timestamps.
	task automatic queue_items(input int count, input int unsigned underflow_pct);
		int unsigned pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if ($urandom_range(99) < underflow_pct) begin
				push_item(KIND_UNDERFLOW, $urandom(), UNSENT_W'($urandom_range(3)));
			end else begin
				if (pick < 80) gen_ts += $urandom_range(2 * stim_intv, stim_intv / 2);
				else if (pick < 88) gen_ts += $urandom_range(255);
				else if (pick < 94) gen_ts = $urandom();
				else gen_ts -= $urandom_range(5000, 1);
				push_item(KIND_TICK, gen_ts, UNSENT_W'($urandom_range(3)));
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_index,
			input logic [CFG_DATA_W-1:0] reg_data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= reg_index;
		cfg_data <= reg_data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// The 16-bit registers get random upper data bits, which must be dropped.
	task automatic write_regs(input logic [BPT_W-1:0] bpt, input logic [INTV_W-1:0] intv,
			input logic [FB_W-1:0] fb);
		write_reg(REG_BYTES_PER_TICK, {4'($urandom), bpt});
		write_reg(REG_INTERVAL_US, intv);
		write_reg(REG_FRAME_BYTES, {4'($urandom), fb});
		stim_intv = 32'(intv);
	endtask

	// Waits until every item is taken and every result is in, then lets an
	// underflow still in flight finish.
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_items.size() != 0 || in_valid || expected_frames.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Test sequence.
	initial begin
		logic [BPT_W-1:0] rnd_bpt;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed items at the reset settings: first tick, zero elapsed time,
		// every refund count, backward and wrapping timestamps, saturation and cap.
		set_idling(0, 0);
		push_item(KIND_TICK, 32'd0, 2'd3);
		push_item(KIND_TICK, 32'd20000, 2'd0);
		push_item(KIND_TICK, 32'd40000, 2'd1);
		push_item(KIND_UNDERFLOW, 32'hFFFF_FFFF, 2'd3);
		push_item(KIND_UNDERFLOW, 32'd0, 2'd0);
		push_item(KIND_TICK, 32'd40000, 2'd2);
		push_item(KIND_TICK, 32'd40001, 2'd0);
		push_item(KIND_UNDERFLOW, 32'h5555_5555, 2'd1);
		push_item(KIND_UNDERFLOW, 32'hAAAA_AAAA, 2'd2);
		push_item(KIND_TICK, 32'd0, 2'd0);
		push_item(KIND_TICK, 32'hFFFF_FFFF, 2'd3);
		push_item(KIND_TICK, 32'h0000_0000, 2'd0);
		push_item(KIND_TICK, 32'h8000_0000, 2'd0);
		push_item(KIND_TICK, 32'h7FFF_FFFF, 2'd0);
		push_item(KIND_TICK, 32'h8000_EA5F, 2'd0);
		push_item(KIND_TICK, 32'h8002_6AFF, 2'd0);
		push_item(KIND_TICK, 32'h8002_B91F, 2'd0);
		gen_ts = 32'h8002_B91F;
		wait_drained();

		// Zero interval and zero frame size, both taken as one.
		write_regs(16'hFFFF, 20'd0, 16'd0);
		push_item(KIND_TICK, gen_ts + 1, 2'd0);
		push_item(KIND_UNDERFLOW, 32'd0, 2'd3);
		push_item(KIND_TICK, gen_ts + 1, 2'd0);
		push_item(KIND_UNDERFLOW, 32'd0, 2'd2);
		push_item(KIND_TICK, gen_ts + 1, 2'd0);
		gen_ts = gen_ts + 1;
		wait_drained();

		// Largest rate, shortest interval, smallest frame: the cap most of the time.
		write_regs(16'hFFFF, 20'd1000, 16'd1);
		queue_items(140, 30);
		wait_drained();

		// No credit from time at all; a long run of refunds saturates the credit.
		set_idling(74, 0);
		write_regs(16'd0, 20'hFFFFF, 16'hFFFF);
		repeat (90) push_item(KIND_UNDERFLOW, $urandom(), 2'd3);
		push_item(KIND_TICK, gen_ts, 2'd0);
		queue_items(100, 50);
		wait_drained();

		// Back to the defaults with a slow receiver.
		set_idling(0, 74);
		write_regs(BPT_RST, INTV_RST, FB_RST);
		queue_items(120, 20);
		wait_drained();

		// The receiver holds off while items keep coming, so the block fills up.
		set_idling(0, 0);
		queue_items(40, 20);
		@(posedge clk);
		long_hold <= 1'b1;
		do @(posedge clk); while (hold_cnt != HOLD_CYCLES);
		long_hold <= 1'b0;
		set_idling(20, 20);
		queue_items(100, 20);
		wait_drained();
		queue_items(100, 20);
		wait_drained();

		// Random settings, some with a frame size near the rate so frames come often.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: set_idling(0, 0);
				1: set_idling(74, 0);
				2: set_idling(0, 74);
				default: set_idling(20, 20);
			endcase
			rnd_bpt = BPT_W'($urandom());
			if (p % 2 == 0) begin
				write_regs(rnd_bpt, INTV_W'($urandom_range(20'hFFFFF, 1000)),
					FB_W'($urandom_range(16'hFFFF, 1)));
			end else begin
				write_regs(rnd_bpt, INTV_W'($urandom_range(100000, 1000)),
					FB_W'(rnd_bpt / $urandom_range(4, 1) + 1));
			end
			queue_items(120, 25);
			wait_drained();
		end

		if (error_count == 0 && expected_frames.size() == 0) begin
			$display("PASS pcm_frame_credit_pacer");
		end else begin
			$display("FAIL pcm_frame_credit_pacer");
		end
		$finish;
	end

endmodule

### pcm_frame_credit_pacer.f
rtl/core/pfcp_pkg.sv
rtl/core/pfcp_alu.sv
rtl/core/pfcp_cfg.sv
rtl/core/pcm_frame_credit_pacer.sv
rtl/core/pfcp_checker.sv
tb/pcm_frame_credit_pacer_test.sv
